// ===== src/sadc_pkg.sv =====
// shared types and constants for the serial adc channel read sequencer
package sadc_pkg;

    localparam int COMMAND_BITS = 6;
    localparam int SAMPLE_BITS  = 12;
    localparam int LED_BITS     = 10;
    localparam int WAIT_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SETUP_WAIT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SELECT_PULSE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CONVERT_WAIT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COMMAND_CH0  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COMMAND_CH1  = 3'd4;

    localparam logic [WAIT_BITS-1:0]    SETUP_WAIT_RESET   = 16'd200;
    localparam logic [WAIT_BITS-1:0]    SELECT_PULSE_RESET = 16'd20;
    localparam logic [WAIT_BITS-1:0]    CONVERT_WAIT_RESET = 16'd1000;
    localparam logic [COMMAND_BITS-1:0] COMMAND_CH0_RESET  = 6'h22;
    localparam logic [COMMAND_BITS-1:0] COMMAND_CH1_RESET  = 6'h32;

    typedef struct packed {
        logic channel_switch;
        logic data_out_pin;
    } tick_t;

    typedef struct packed {
        logic                   serial_clock;
        logic                   chip_select;
        logic                   data_in_pin;
        logic                   sample_done;
        logic [SAMPLE_BITS-1:0] sample_value;
        logic [LED_BITS-1:0]    led_value;
        logic                   active_channel;
    } result_t;

endpackage

// ===== src/spi_adc_channel_read_sequencer.sv =====
// serial adc read sequencer: command frame, waits, select pulse, read frame
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+----------------------------
//  tick      | in        | tick_valid/tick_stall | channel switch, data-out pin
//  result    | out       | result_valid/_stall   | pins, sample, leds, channel
//  config    | in        | cfg_write             | cfg_index, cfg_data
//
// one tick is taken per cycle unless stalled; its result appears in the output
// register on the next cycle. the sequencer state advances as the tick is taken.
// reset puts the sequencer at the start of a command frame, registers at defaults.
// tick_stall is raised only while a result is held and the receiver stalls.
module spi_adc_channel_read_sequencer
    import sadc_pkg::*;
#(
    parameter int FRAME_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    tick_valid,
    output logic                    tick_stall,
    input  tick_t                   tick,
    output logic                    result_valid,
    input  logic                    result_stall,
    output result_t                 result,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WAIT_BITS-1:0]    cfg_data
);

    localparam int BIT_W = $clog2(FRAME_BITS);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(FRAME_BITS - 1);

    typedef enum logic [2:0] {
        PH_CMD,
        PH_SETUP,
        PH_SELECT,
        PH_CONVERT,
        PH_READ
    } phase_t;

    logic [WAIT_BITS-1:0]    setup_wait_reg, select_pulse_reg, convert_wait_reg;
    logic [COMMAND_BITS-1:0] command_ch0_reg, command_ch1_reg;

    phase_t                  phase_reg, phase_next;
    logic [BIT_W-1:0]        bit_index_reg, bit_index_next;
    logic                    clock_high_reg, clock_high_next;
    logic [WAIT_BITS-1:0]    wait_count_reg, wait_count_next;
    logic [COMMAND_BITS-1:0] command_word_reg, command_word_next;
    logic [SAMPLE_BITS-1:0]  shift_in_reg, shift_in_next;
    logic [SAMPLE_BITS-1:0]  held_sample_reg, held_sample_next;
    logic                    channel_latch_reg, channel_latch_next;

    logic                    result_valid_reg;
    result_t                 result_reg, result_next;

    logic                    accept;
    logic                    do_enter;
    phase_t                  enter_from;
    logic [WAIT_BITS-1:0]    wait_dec;
    logic [FRAME_BITS-1:0]   frame_word;

    assign tick_stall   = result_valid_reg & result_stall;
    assign accept       = tick_valid & ~tick_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        bit_index_next     = bit_index_reg;
        clock_high_next    = clock_high_reg;
        wait_count_next    = wait_count_reg;
        command_word_next  = command_word_reg;
        shift_in_next      = shift_in_reg;
        held_sample_next   = held_sample_reg;
        channel_latch_next = channel_latch_reg;
        do_enter           = 1'b0;
        enter_from         = PH_SETUP;
        wait_dec           = '0;
        frame_word         = '0;

        result_next = '0;

        case (phase_reg)
            PH_CMD, PH_READ:
            begin
                // channel and command are taken on the first tick of a frame
                if (phase_reg == PH_CMD && bit_index_reg == '0 && !clock_high_reg)
                begin
                    channel_latch_next = tick.channel_switch;
                    command_word_next  = tick.channel_switch ? command_ch1_reg
                                                             : command_ch0_reg;
                end
                frame_word = FRAME_BITS'(command_word_next) << (FRAME_BITS - COMMAND_BITS);
                result_next.data_in_pin = frame_word[LAST_BIT - bit_index_reg];
                if (!clock_high_reg)
                begin
                    result_next.serial_clock = 1'b1;
                    if (phase_reg == PH_READ)
                    begin
                        shift_in_next = {shift_in_reg[SAMPLE_BITS-2:0], tick.data_out_pin};
                    end
                    clock_high_next = 1'b1;
                end
                else
                begin
                    clock_high_next = 1'b0;
                    if (bit_index_reg == LAST_BIT)
                    begin
                        if (phase_reg == PH_READ)
                        begin
                            held_sample_next        = shift_in_reg;
                            result_next.sample_done = 1'b1;
                            phase_next              = PH_CMD;
                            bit_index_next          = '0;
                        end
                        else
                        begin
                            do_enter   = 1'b1;
                            enter_from = PH_SETUP;
                        end
                    end
                    else
                    begin
                        bit_index_next = bit_index_reg + 1'b1;
                    end
                end
            end
            PH_SETUP, PH_SELECT, PH_CONVERT:
            begin
                result_next.chip_select = (phase_reg == PH_SELECT);
                wait_dec        = (wait_count_reg == '0) ? '0 : wait_count_reg - 1'b1;
                wait_count_next = wait_dec;
                if (wait_dec == '0)
                begin
                    do_enter = 1'b1;
                    case (phase_reg)
                        PH_SETUP:   enter_from = PH_SELECT;
                        PH_SELECT:  enter_from = PH_CONVERT;
                        default:    enter_from = PH_READ;
                    endcase
                end
            end
            default:
            begin
                phase_next      = PH_CMD;
                bit_index_next  = '0;
                clock_high_next = 1'b0;
            end
        endcase

        // phase entry, zero-length waits fall through to the next phase
        if (do_enter)
        begin
            bit_index_next  = '0;
            clock_high_next = 1'b0;
            if (enter_from == PH_SETUP && setup_wait_reg != '0)
            begin
                phase_next      = PH_SETUP;
                wait_count_next = setup_wait_reg;
            end
            else if ((enter_from inside {PH_SETUP, PH_SELECT}) && select_pulse_reg != '0)
            begin
                phase_next      = PH_SELECT;
                wait_count_next = select_pulse_reg;
            end
            else if (enter_from != PH_READ && convert_wait_reg != '0)
            begin
                phase_next      = PH_CONVERT;
                wait_count_next = convert_wait_reg;
            end
            else
            begin
                phase_next    = PH_READ;
                shift_in_next = '0;
            end
        end

        result_next.sample_value   = held_sample_next;
        result_next.led_value      = held_sample_next[SAMPLE_BITS-1 -: LED_BITS];
        result_next.active_channel = channel_latch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_wait_reg   <= SETUP_WAIT_RESET;
            select_pulse_reg <= SELECT_PULSE_RESET;
            convert_wait_reg <= CONVERT_WAIT_RESET;
            command_ch0_reg  <= COMMAND_CH0_RESET;
            command_ch1_reg  <= COMMAND_CH1_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SETUP_WAIT:   setup_wait_reg   <= cfg_data;
                REG_SELECT_PULSE: select_pulse_reg <= cfg_data;
                REG_CONVERT_WAIT: convert_wait_reg <= cfg_data;
                REG_COMMAND_CH0:  command_ch0_reg  <= cfg_data[COMMAND_BITS-1:0];
                REG_COMMAND_CH1:  command_ch1_reg  <= cfg_data[COMMAND_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_CMD;
            bit_index_reg     <= '0;
            clock_high_reg    <= 1'b0;
            wait_count_reg    <= '0;
            command_word_reg  <= '0;
            shift_in_reg      <= '0;
            held_sample_reg   <= '0;
            channel_latch_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                bit_index_reg     <= bit_index_next;
                clock_high_reg    <= clock_high_next;
                wait_count_reg    <= wait_count_next;
                command_word_reg  <= command_word_next;
                shift_in_reg      <= shift_in_next;
                held_sample_reg   <= held_sample_next;
                channel_latch_reg <= channel_latch_next;
                result_valid_reg  <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on every taken tick
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== verif/spi_adc_channel_read_sequencer_test.sv =====
// testbench for the serial adc channel read sequencer: predicted pin and sample stream
module spi_adc_channel_read_sequencer_test
    import sadc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LEN   = 12;
    localparam int HOLD_CYCLES = 100;
    localparam int QUIET_LIMIT = 2000;

    typedef enum logic [2:0] {PH_CMD, PH_SETUP, PH_SELECT, PH_CONVERT, PH_READ} seq_phase_t;
    typedef enum {PIN_RANDOM, PIN_HIGH, PIN_LOW} pin_drive_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    tick_valid = 1'b0;
    logic                    tick_stall;
    tick_t                   tick = '0;
    logic                    result_valid;
    logic                    result_stall = 1'b0;
    result_t                 result;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [WAIT_BITS-1:0]    cfg_data = '0;

    // predicted sequencer state and register copies
    seq_phase_t              phase;
    logic [3:0]              bit_idx;
    logic                    sclk_high;
    logic [WAIT_BITS-1:0]    wait_cnt;
    logic [COMMAND_BITS-1:0] cmd_word;
    logic [SAMPLE_BITS-1:0]  shift_reg;
    logic [SAMPLE_BITS-1:0]  held_sample;
    logic                    chan_latch;
    logic [WAIT_BITS-1:0]    setup_len;
    logic [WAIT_BITS-1:0]    pulse_len;
    logic [WAIT_BITS-1:0]    convert_len;
    logic [COMMAND_BITS-1:0] cmd_ch0;
    logic [COMMAND_BITS-1:0] cmd_ch1;

    result_t due_results[$];
    int      samples_predicted = 0;
    int      mismatch_count = 0;
    int      send_gap_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_requests = 0;
    int      hold_served = 0;
    int      hold_left = 0;
    int      quiet_cycles = 0;

    spi_adc_channel_read_sequencer #(.FRAME_BITS(FRAME_LEN)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [WAIT_BITS-1:0] phase_len(seq_phase_t p);
        case (p)
            PH_SETUP:   return setup_len;
            PH_SELECT:  return pulse_len;
            PH_CONVERT: return convert_len;
            default:    return '0;
        endcase
    endfunction

    // zero-length waits are skipped straight through
    function automatic void enter_phase(seq_phase_t p);
        while ((p == PH_SETUP || p == PH_SELECT || p == PH_CONVERT) && phase_len(p) == '0)
            p = seq_phase_t'(p + 1);
        if (p != PH_CMD && p != PH_READ)
            wait_cnt = phase_len(p);
        phase = p;
        bit_idx = '0;
        sclk_high = 1'b0;
        if (p == PH_READ)
            shift_reg = '0;
    endfunction

    function automatic result_t advance_sequencer(tick_t t);
        result_t r;
        r = '0;
        if (phase == PH_CMD || phase == PH_READ)
        begin
            if (phase == PH_CMD && bit_idx == '0 && !sclk_high)
            begin
                chan_latch = t.channel_switch;
                cmd_word = t.channel_switch ? cmd_ch1 : cmd_ch0;
            end
            r.data_in_pin = (bit_idx < COMMAND_BITS) ?
                            cmd_word[COMMAND_BITS - 1 - int'(bit_idx)] : 1'b0;
            if (!sclk_high)
            begin
                r.serial_clock = 1'b1;
                if (phase == PH_READ)
                    shift_reg = {shift_reg[SAMPLE_BITS-2:0], t.data_out_pin};
                sclk_high = 1'b1;
            end
            else
            begin
                sclk_high = 1'b0;
                if (int'(bit_idx) == FRAME_LEN - 1)
                begin
                    if (phase == PH_READ)
                    begin
                        held_sample = shift_reg;
                        r.sample_done = 1'b1;
                        enter_phase(PH_CMD);
                    end
                    else
                        enter_phase(PH_SETUP);
                end
                else
                    bit_idx++;
            end
        end
        else
        begin
            r.chip_select = (phase == PH_SELECT);
            if (wait_cnt != '0)
                wait_cnt--;
            if (wait_cnt == '0)
                enter_phase(seq_phase_t'(phase + 1));
        end
        r.sample_value = held_sample;
        r.led_value = held_sample[SAMPLE_BITS-1 -: LED_BITS];
        r.active_channel = chan_latch;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch("result with nothing expected", '0, '0);
            return;
        end
        want = due_results.pop_front();
        if (got.serial_clock !== want.serial_clock)
            report_mismatch("serial_clock", 32'(got.serial_clock), 32'(want.serial_clock));
        if (got.chip_select !== want.chip_select)
            report_mismatch("chip_select", 32'(got.chip_select), 32'(want.chip_select));
        if (got.data_in_pin !== want.data_in_pin)
            report_mismatch("data_in_pin", 32'(got.data_in_pin), 32'(want.data_in_pin));
        if (got.sample_done !== want.sample_done)
            report_mismatch("sample_done", 32'(got.sample_done), 32'(want.sample_done));
        if (got.sample_value !== want.sample_value)
            report_mismatch("sample_value", 32'(got.sample_value), 32'(want.sample_value));
        if (got.led_value !== want.led_value)
            report_mismatch("led_value", 32'(got.led_value), 32'(want.led_value));
        if (got.active_channel !== want.active_channel)
            report_mismatch("active_channel", 32'(got.active_channel),
                            32'(want.active_channel));
    endtask

    // result side: check each transfer, then pick the stall for the next edge
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result(result);
        if (hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tick_valid && !tick_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("spi_adc_channel_read_sequencer_test: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_tick(tick_t t);
        result_t want;
        while ($urandom_range(99) < send_gap_pct)
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick <= t;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        want = advance_sequencer(t);
        due_results.push_back(want);
        if (want.sample_done)
            samples_predicted++;
    endtask

    function automatic tick_t make_tick(pin_drive_t drive);
        tick_t t;
        t.channel_switch = 1'($urandom_range(1));
        case (drive)
            PIN_HIGH: t.data_out_pin = 1'b1;
            PIN_LOW:  t.data_out_pin = 1'b0;
            default:  t.data_out_pin = 1'($urandom_range(1));
        endcase
        return t;
    endfunction

    task automatic run_ticks(int count);
        repeat (count)
            send_tick(make_tick(PIN_RANDOM));
    endtask

    // ends right after a report, so the next tick opens a frame
    task automatic run_frames(int count, pin_drive_t drive);
        int target;
        target = samples_predicted + count;
        while (samples_predicted < target)
            send_tick(make_tick(drive));
    endtask

    task automatic drain();
        tick_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [WAIT_BITS-1:0] data);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SETUP_WAIT:   setup_len = data;
            REG_SELECT_PULSE: pulse_len = data;
            REG_CONVERT_WAIT: convert_len = data;
            REG_COMMAND_CH0:  cmd_ch0 = data[COMMAND_BITS-1:0];
            REG_COMMAND_CH1:  cmd_ch1 = data[COMMAND_BITS-1:0];
            default:          ;
        endcase
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_gap_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic logic [WAIT_BITS-1:0] pick_wait();
        if ($urandom_range(15) < 12)
            return WAIT_BITS'($urandom_range(4));
        return WAIT_BITS'($urandom_range(40));
    endfunction

    // default command and setup wait, into the select pulse; the convert wait
    // is cut short while the pulse runs so the frame finishes quickly
    task automatic test_reset_defaults();
        run_ticks(230);
        write_reg(REG_CONVERT_WAIT, 16'd3);
        run_frames(1, PIN_RANDOM);
    endtask

    task automatic test_zero_waits();
        write_reg(REG_SETUP_WAIT, '0);
        write_reg(REG_SELECT_PULSE, '0);
        write_reg(REG_CONVERT_WAIT, '0);
        write_reg(REG_COMMAND_CH0, '0);
        write_reg(REG_COMMAND_CH1, '1);
        run_frames(2, PIN_HIGH);
        run_frames(2, PIN_LOW);
    endtask

    task automatic test_short_waits();
        write_reg(REG_SETUP_WAIT, 16'd1);
        write_reg(REG_SELECT_PULSE, 16'd1);
        write_reg(REG_CONVERT_WAIT, 16'd1);
        write_reg(REG_COMMAND_CH0, 16'h003f);
        write_reg(REG_COMMAND_CH1, 16'hffc0);
        run_frames(3, PIN_RANDOM);
    endtask

    task automatic test_unknown_index();
        int idx;
        for (idx = REG_COMMAND_CH1 + 1; idx < 2 ** CFG_IDX_BITS; idx++)
            write_reg(CFG_IDX_BITS'(idx), WAIT_BITS'($urandom));
        run_frames(2, PIN_RANDOM);
    endtask

    task automatic test_long_waits();
        run_frames(1, PIN_RANDOM);
        write_reg(REG_SETUP_WAIT, 16'd50);
        write_reg(REG_SELECT_PULSE, 16'd30);
        write_reg(REG_CONVERT_WAIT, 16'd60);
        run_frames(1, PIN_HIGH);
        write_reg(REG_SETUP_WAIT, 16'd2);
        write_reg(REG_SELECT_PULSE, 16'd3);
        write_reg(REG_CONVERT_WAIT, 16'd2);
    endtask

    // receiver holds off while ticks keep coming, so the block backs up
    task automatic test_backpressure();
        hold_requests++;
        run_ticks(HOLD_CYCLES + 50);
    endtask

    task automatic test_random_ticks(int count);
        int sent;
        int chunk;
        sent = 0;
        while (sent < count)
        begin
            write_reg(REG_SETUP_WAIT, pick_wait());
            write_reg(REG_SELECT_PULSE, pick_wait());
            write_reg(REG_CONVERT_WAIT, pick_wait());
            write_reg(REG_COMMAND_CH0, WAIT_BITS'($urandom));
            write_reg(REG_COMMAND_CH1, WAIT_BITS'($urandom));
            if ($urandom_range(3) == 0)
                write_reg(CFG_IDX_BITS'(REG_COMMAND_CH1 + 1 + $urandom_range(2)),
                          WAIT_BITS'($urandom));
            chunk = $urandom_range(30, 60);
            run_ticks(chunk);
            sent += chunk;
        end
    endtask

    initial
    begin
        phase = PH_CMD;
        bit_idx = '0;
        sclk_high = 1'b0;
        wait_cnt = '0;
        cmd_word = '0;
        shift_reg = '0;
        held_sample = '0;
        chan_latch = 1'b0;
        setup_len = SETUP_WAIT_RESET;
        pulse_len = SELECT_PULSE_RESET;
        convert_len = CONVERT_WAIT_RESET;
        cmd_ch0 = COMMAND_CH0_RESET;
        cmd_ch1 = COMMAND_CH1_RESET;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(10, 46);
        test_reset_defaults();
        test_zero_waits();
        test_short_waits();
        test_unknown_index();
        test_random_ticks(100);

        set_idling(46, 10);
        test_random_ticks(100);

        set_idling(0, 0);
        test_long_waits();
        test_backpressure();
        test_random_ticks(100);

        drain();
        repeat (4) @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch("results never delivered", due_results.size(), 0);
        if (mismatch_count == 0)
            $display("spi_adc_channel_read_sequencer_test: done, clean");
        else
            $display("spi_adc_channel_read_sequencer_test: done, errors");
        $finish;
    end

endmodule
